FILE: src/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types and constants for the page replacement unit: policy codes,
// configuration register indices and fixed field widths.
// ----------------------------------------------------------------------------
package prc_pkg;

	// fixed field widths
	localparam int unsigned PAGE_IN_W   = 16;
	localparam int unsigned FRAME_IDX_W = 4;
	localparam int unsigned EV_PAGE_W   = 16;
	localparam int unsigned STAMP_W     = 32;
	localparam int unsigned COUNT_W     = 32;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 5;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_POLICY_MODE = 1'd0;
	localparam cfg_idx_t REG_FRAMES_USED = 1'd1;

	// replacement policy codes; the spare code behaves as FIFO
	typedef logic [1:0] policy_t;

	localparam policy_t POLICY_FIFO  = 2'd0;
	localparam policy_t POLICY_LRU   = 2'd1;
	localparam policy_t POLICY_CLOCK = 2'd2;

	localparam policy_t    POLICY_RESET      = POLICY_FIFO;
	localparam logic [4:0] FRAMES_USED_RESET = 5'd16;

endpackage

FILE: src/prc_ram.sv
// ----------------------------------------------------------------------------
// prc_ram
// Generic simple dual port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module prc_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/page_replacement_fifo_lru_clock.sv
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru_clock
// Page replacement unit (FIFO, LRU, second chance clock) with one result
// per page reference.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// its result is out. The result appears on the output ports for one cycle
// with done high, and must be captured then: there is no back-pressure.
// One pass over the n active frames reads page and stamp RAMs one frame a
// cycle and finds a hit, the first empty frame and the oldest frame at once.
// A hit goes to S_HIT; a fault with an empty frame to S_WRITE; an eviction
// reads the victim in S_VREQ and S_VWAIT, then S_WRITE, and under clock first
// reduces the hand modulo n in S_MOD and clears reference bits in S_SWEEP.
// done rises on the return to idle; a new item may start while it is high.
// The configuration port is always ready; write it only while busy is low.
// ----------------------------------------------------------------------------
module page_replacement_fifo_lru_clock #(
	parameter int unsigned FRAMES    = 16,
	parameter int unsigned PAGE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [prc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [prc_pkg::CFG_DATA_W-1:0]    cfg_data,

	input  logic                              start,
	output logic                              busy,
	input  logic [prc_pkg::PAGE_IN_W-1:0]     page_number,
	input  logic                              last_reference,

	output logic                              done,
	output logic                              hit,
	output logic [prc_pkg::FRAME_IDX_W-1:0]   frame_index,
	output logic                              evicted_valid,
	output logic [prc_pkg::EV_PAGE_W-1:0]     evicted_page,
	output logic [prc_pkg::COUNT_W-1:0]       fault_count,
	output logic                              final_result
);

	localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int unsigned NW = $clog2(FRAMES + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_HIT,
		S_MOD,
		S_SWEEP,
		S_VREQ,
		S_VWAIT,
		S_WRITE
	} state_t;

	state_t state_q;

	// configuration
	prc_pkg::policy_t policy_q;
	logic [4:0]       frames_used_q;

	// per-frame flags
	logic [FRAMES-1:0] valid_q;
	logic [FRAMES-1:0] ref_q;

	logic [IW-1:0]                 hand_q;
	logic [prc_pkg::STAMP_W-1:0]   time_q;
	logic [prc_pkg::COUNT_W-1:0]   fault_q;

	// item context
	logic [PAGE_BITS-1:0] page_q;
	logic                 last_q;
	logic [NW-1:0]        idx_q;
	logic                 chk_vld_s1;
	logic [IW-1:0]        chk_idx_s1;
	logic                 empty_q;
	logic [IW-1:0]        empty_idx_q;
	logic [IW-1:0]        best_idx_q;
	logic [prc_pkg::STAMP_W-1:0] best_age_q;
	logic [IW-1:0]        slot_q;
	logic [IW-1:0]        hw_q;
	logic [NW-1:0]        sw_cnt_q;
	logic                 ev_valid_q;
	logic [PAGE_BITS-1:0] ev_page_q;

	// result registers
	logic                              done_q;
	logic                              hit_q;
	logic [prc_pkg::FRAME_IDX_W-1:0]   frame_index_q;
	logic                              evicted_valid_q;
	logic [prc_pkg::EV_PAGE_W-1:0]     evicted_page_q;
	logic [prc_pkg::COUNT_W-1:0]       fault_count_q;
	logic                              final_result_q;

	// RAM ports
	logic [IW-1:0]               rd_addr;
	logic [PAGE_BITS-1:0]        page_rd;
	logic [prc_pkg::STAMP_W-1:0] stamp_rd;
	logic                        page_we;
	logic                        stamp_we;

	// combinational helpers
	logic [8:0]                  fu_ext;
	logic [8:0]                  n_ext;
	logic [NW-1:0]               n_act;
	logic                        mode_lru;
	logic                        mode_clock;
	logic                        accept;
	logic [31:0]                 page_in_ext;
	logic                        chk_valid_bit;
	logic                        chk_match;
	logic                        chk_empty_new;
	logic [prc_pkg::STAMP_W-1:0] chk_age;
	logic                        chk_better;
	logic                        chk_last;
	logic [NW-1:0]               hw_ext;
	logic [NW-1:0]               hw_sub;
	logic [IW-1:0]               hw_next;
	logic [IW-1:0]               slot_next;
	logic [31:0]                 slot_ext;
	logic [31:0]                 ev_page_ext;

	always_comb begin
		fu_ext = 9'(frames_used_q);
		if (fu_ext == 9'd0) begin
			n_ext = 9'd1;
		end else if (fu_ext > 9'(FRAMES)) begin
			n_ext = 9'(FRAMES);
		end else begin
			n_ext = fu_ext;
		end
		n_act = NW'(n_ext);
	end

	assign mode_lru    = (policy_q == prc_pkg::POLICY_LRU);
	assign mode_clock  = (policy_q == prc_pkg::POLICY_CLOCK);
	assign accept      = start && (state_q == S_IDLE);
	assign page_in_ext = 32'(page_number);

	// frame check, one frame a cycle
	assign chk_valid_bit = valid_q[chk_idx_s1];
	assign chk_match     = chk_valid_bit && (page_rd == page_q);
	assign chk_empty_new = !chk_valid_bit && !empty_q;
	assign chk_age       = time_q - stamp_rd;
	assign chk_better    = (chk_idx_s1 == IW'(0)) || (chk_age > best_age_q);
	assign chk_last      = ((NW'(chk_idx_s1) + NW'(1)) == n_act);

	// clock hand arithmetic
	assign hw_ext    = NW'(hw_q);
	assign hw_sub    = hw_ext - n_act;
	assign hw_next   = ((hw_ext + NW'(1)) == n_act) ? IW'(0) : IW'(hw_ext + NW'(1));
	assign slot_next = ((NW'(slot_q) + NW'(1)) == n_act) ? IW'(0)
	                                                   : IW'(NW'(slot_q) + NW'(1));
	assign slot_ext    = 32'(slot_q);
	assign ev_page_ext = 32'(ev_page_q);

	assign rd_addr  = (state_q == S_SCAN) ? idx_q[IW-1:0] : slot_q;
	assign page_we  = (state_q == S_WRITE);
	assign stamp_we = (state_q == S_WRITE) || ((state_q == S_HIT) && mode_lru);

	prc_ram #(
		.WIDTH (PAGE_BITS),
		.DEPTH (FRAMES)
	) u_page_ram (
		.clk   (clk),
		.we    (page_we),
		.waddr (slot_q),
		.wdata (page_q),
		.raddr (rd_addr),
		.rdata (page_rd)
	);

	prc_ram #(
		.WIDTH (prc_pkg::STAMP_W),
		.DEPTH (FRAMES)
	) u_stamp_ram (
		.clk   (clk),
		.we    (stamp_we),
		.waddr (slot_q),
		.wdata (time_q),
		.raddr (rd_addr),
		.rdata (stamp_rd)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q      <= prc_pkg::POLICY_RESET;
			frames_used_q <= prc_pkg::FRAMES_USED_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				prc_pkg::REG_POLICY_MODE: begin
					policy_q <= cfg_data[1:0];
				end
				prc_pkg::REG_FRAMES_USED: begin
					frames_used_q <= cfg_data[4:0];
				end
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			valid_q         <= '0;
			ref_q           <= '0;
			hand_q          <= '0;
			time_q          <= '0;
			fault_q         <= '0;
			chk_vld_s1      <= 1'b0;
			done_q          <= 1'b0;
			page_q          <= '0;
			last_q          <= 1'b0;
			idx_q           <= '0;
			chk_idx_s1      <= '0;
			empty_q         <= 1'b0;
			empty_idx_q     <= '0;
			best_idx_q      <= '0;
			best_age_q      <= '0;
			slot_q          <= '0;
			hw_q            <= '0;
			sw_cnt_q        <= '0;
			ev_valid_q      <= 1'b0;
			ev_page_q       <= '0;
			hit_q           <= 1'b0;
			frame_index_q   <= '0;
			evicted_valid_q <= 1'b0;
			evicted_page_q  <= '0;
			fault_count_q   <= '0;
			final_result_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					chk_vld_s1 <= 1'b0;
					if (accept) begin
						page_q     <= page_in_ext[PAGE_BITS-1:0];
						last_q     <= last_reference;
						idx_q      <= '0;
						empty_q    <= 1'b0;
						ev_valid_q <= 1'b0;
						ev_page_q  <= '0;
						state_q    <= S_SCAN;
					end
				end

				S_SCAN: begin
					// each check uses the read issued in the cycle before
					if (idx_q < n_act) begin
						chk_vld_s1 <= 1'b1;
						chk_idx_s1 <= idx_q[IW-1:0];
						idx_q      <= idx_q + NW'(1);
					end else begin
						chk_vld_s1 <= 1'b0;
					end
					if (chk_vld_s1) begin
						if (chk_match) begin
							slot_q  <= chk_idx_s1;
							state_q <= S_HIT;
						end else begin
							if (chk_empty_new) begin
								empty_q     <= 1'b1;
								empty_idx_q <= chk_idx_s1;
							end
							if (chk_better) begin
								best_idx_q <= chk_idx_s1;
								best_age_q <= chk_age;
							end
							if (chk_last) begin
								fault_q <= fault_q + prc_pkg::COUNT_W'(1);
								if (chk_empty_new) begin
									slot_q  <= chk_idx_s1;
									state_q <= S_WRITE;
								end else if (empty_q) begin
									slot_q  <= empty_idx_q;
									state_q <= S_WRITE;
								end else if (mode_clock) begin
									hw_q    <= hand_q;
									state_q <= S_MOD;
								end else begin
									slot_q  <= chk_better ? chk_idx_s1 : best_idx_q;
									state_q <= S_VREQ;
								end
							end
						end
					end
				end

				S_HIT: begin
					chk_vld_s1 <= 1'b0;
					if (mode_clock) begin
						ref_q[slot_q] <= 1'b1;
					end
					time_q          <= time_q + prc_pkg::STAMP_W'(1);
					done_q          <= 1'b1;
					hit_q           <= 1'b1;
					frame_index_q   <= slot_ext[prc_pkg::FRAME_IDX_W-1:0];
					evicted_valid_q <= 1'b0;
					evicted_page_q  <= '0;
					fault_count_q   <= fault_q;
					final_result_q  <= last_q;
					state_q         <= S_IDLE;
				end

				S_MOD: begin
					// hand modulo n by repeated subtraction
					chk_vld_s1 <= 1'b0;
					if (hw_ext >= n_act) begin
						hw_q <= IW'(hw_sub);
					end else begin
						sw_cnt_q <= '0;
						state_q  <= S_SWEEP;
					end
				end

				S_SWEEP: begin
					if ((sw_cnt_q < n_act) && ref_q[hw_q]) begin
						ref_q[hw_q] <= 1'b0;
						hw_q        <= hw_next;
						sw_cnt_q    <= sw_cnt_q + NW'(1);
					end else begin
						slot_q  <= hw_q;
						state_q <= S_VREQ;
					end
				end

				S_VREQ: begin
					chk_vld_s1 <= 1'b0;
					state_q    <= S_VWAIT;
				end

				S_VWAIT: begin
					ev_valid_q <= 1'b1;
					ev_page_q  <= page_rd;
					state_q    <= S_WRITE;
				end

				S_WRITE: begin
					chk_vld_s1     <= 1'b0;
					valid_q[slot_q] <= 1'b1;
					ref_q[slot_q]   <= 1'b0;
					if (mode_clock) begin
						hand_q <= slot_next;
					end
					time_q          <= time_q + prc_pkg::STAMP_W'(1);
					done_q          <= 1'b1;
					hit_q           <= 1'b0;
					frame_index_q   <= slot_ext[prc_pkg::FRAME_IDX_W-1:0];
					evicted_valid_q <= ev_valid_q;
					evicted_page_q  <= ev_page_ext[prc_pkg::EV_PAGE_W-1:0];
					fault_count_q   <= fault_q;
					final_result_q  <= last_q;
					state_q         <= S_IDLE;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cfg_ready     = 1'b1;
	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign hit           = hit_q;
	assign frame_index   = frame_index_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_page  = evicted_page_q;
	assign fault_count   = fault_count_q;
	assign final_result  = final_result_q;

endmodule

FILE: sim/page_replacement_check.sv
// ----------------------------------------------------------------------------
// page_replacement_check
// Watches the configuration, request and result channels of the page
// replacement unit, predicts every result from its own copy of the frame
// table and compares each result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module page_replacement_check
	import prc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,

	input  logic                    start,
	input  logic                    busy,
	input  logic [PAGE_IN_W-1:0]    page_number,
	input  logic                    last_reference,

	input  logic                    done,
	input  logic                    hit,
	input  logic [FRAME_IDX_W-1:0]  frame_index,
	input  logic                    evicted_valid,
	input  logic [EV_PAGE_W-1:0]    evicted_page,
	input  logic [COUNT_W-1:0]      fault_count,
	input  logic                    final_result,

	output int unsigned             fail_count,
	output int unsigned             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NFRAMES = 16;

	typedef struct packed {
		logic                   hit;
		logic [FRAME_IDX_W-1:0] frame;
		logic                   ev_valid;
		logic [EV_PAGE_W-1:0]   ev_page;
		logic [COUNT_W-1:0]     faults;
		logic                   final_ref;
	} page_result_t;

	// shadow of the frame table
	logic [PAGE_IN_W-1:0] frame_pg    [NFRAMES];
	bit                   frame_live  [NFRAMES];
	logic [STAMP_W-1:0]   frame_stamp [NFRAMES];
	bit                   ref_bit     [NFRAMES];
	logic [3:0]           hand;
	logic [STAMP_W-1:0]   ref_clock;
	logic [COUNT_W-1:0]   faults;

	policy_t              mode;
	logic [4:0]           frames_cfg;

	page_result_t         expected_results [$];
	int unsigned          mismatches;

	function automatic page_result_t resolve_reference(logic [PAGE_IN_W-1:0] page,
			logic last);
		page_result_t r;
		int n;
		int slot;
		int h;
		int steps;
		bit found;
		bit empty;
		logic [STAMP_W-1:0] age;
		logic [STAMP_W-1:0] best_age;

		n = (frames_cfg == 0) ? 1 : ((frames_cfg > NFRAMES) ? NFRAMES : int'(frames_cfg));
		r = '0;
		found = 0;
		empty = 0;
		slot = 0;
		for (int i = 0; i < n; i++)
			if (!found && frame_live[i] && frame_pg[i] == page) begin
				slot = i;
				found = 1;
			end
		if (found) begin
			r.hit = 1'b1;
			if (mode == POLICY_LRU)
				frame_stamp[slot] = ref_clock;
			else if (mode == POLICY_CLOCK)
				ref_bit[slot] = 1;
		end else begin
			faults++;
			for (int i = 0; i < n; i++)
				if (!empty && !frame_live[i]) begin
					slot = i;
					empty = 1;
				end
			if (!empty) begin
				if (mode == POLICY_CLOCK) begin
					h = hand % n;
					steps = 0;
					while (steps < n && ref_bit[h]) begin
						ref_bit[h] = 0;
						h = (h + 1) % n;
						steps++;
					end
					slot = h;
				end else begin
					// oldest stamp by wrapped age, ties to the lowest frame
					best_age = '0;
					for (int i = 0; i < n; i++) begin
						age = ref_clock - frame_stamp[i];
						if (i == 0 || age > best_age) begin
							slot = i;
							best_age = age;
						end
					end
				end
				r.ev_valid = 1'b1;
				r.ev_page = frame_pg[slot];
			end
			frame_pg[slot] = page;
			frame_live[slot] = 1;
			frame_stamp[slot] = ref_clock;
			ref_bit[slot] = 0;
			if (mode == POLICY_CLOCK)
				hand = 4'((slot + 1) % n);
		end
		ref_clock++;
		r.frame = FRAME_IDX_W'(slot);
		r.faults = faults;
		r.final_ref = last;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		page_result_t got;
		page_result_t want;

		if (!arst_n) begin
			for (int i = 0; i < NFRAMES; i++) begin
				frame_live[i] = 0;
				ref_bit[i] = 0;
			end
			hand = '0;
			ref_clock = '0;
			faults = '0;
			mode = POLICY_RESET;
			frames_cfg = FRAMES_USED_RESET;
			expected_results.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				case (cfg_index)
					REG_POLICY_MODE: mode = policy_t'(cfg_data[1:0]);
					REG_FRAMES_USED: frames_cfg = cfg_data;
					default: ;
				endcase

			// retire the result first: a new item may be taken on the done edge
			if (done) begin
				got = '{hit, frame_index, evicted_valid, evicted_page, fault_count,
					final_result};
				if (expected_results.size() == 0) begin
					$error("result with no item outstanding");
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (got.hit !== want.hit) begin
						$error("hit: expected %0d, actual %0d", want.hit, got.hit);
						mismatches++;
					end
					if (got.frame !== want.frame) begin
						$error("frame_index: expected %0d, actual %0d", want.frame, got.frame);
						mismatches++;
					end
					if (got.ev_valid !== want.ev_valid) begin
						$error("evicted_valid: expected %0d, actual %0d", want.ev_valid,
							got.ev_valid);
						mismatches++;
					end
					if (got.ev_page !== want.ev_page) begin
						$error("evicted_page: expected %h, actual %h", want.ev_page,
							got.ev_page);
						mismatches++;
					end
					if (got.faults !== want.faults) begin
						$error("fault_count: expected %0d, actual %0d", want.faults,
							got.faults);
						mismatches++;
					end
					if (got.final_ref !== want.final_ref) begin
						$error("final_result: expected %0d, actual %0d", want.final_ref,
							got.final_ref);
						mismatches++;
					end
				end
			end

			if (start && !busy)
				expected_results.push_back(resolve_reference(page_number, last_reference));
		end
		fail_count <= mismatches;
		outstanding <= expected_results.size();
	end

endmodule

FILE: sim/page_replacement_fifo_lru_clock_tb.sv
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru_clock_tb
// Drives page references through the replacement unit under every policy and
// a range of frame counts: a directed opening, then phases of references
// drawn from small working sets with random gaps. Results are checked by
// page_replacement_check.
// ----------------------------------------------------------------------------
module page_replacement_fifo_lru_clock_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import prc_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 1250;
	localparam int unsigned POOL_DEPTH   = 24;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;

	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	logic                   start = 1'b0;
	logic                   busy;
	logic [PAGE_IN_W-1:0]   page_number = '0;
	logic                   last_reference = 1'b0;

	logic                   done;
	logic                   hit;
	logic [FRAME_IDX_W-1:0] frame_index;
	logic                   evicted_valid;
	logic [EV_PAGE_W-1:0]   evicted_page;
	logic [COUNT_W-1:0]     fault_count;
	logic                   final_result;

	int unsigned            fail_count;
	int unsigned            outstanding;

	always #6 clk = ~clk;

	page_replacement_fifo_lru_clock uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.start          (start),
		.busy           (busy),
		.page_number    (page_number),
		.last_reference (last_reference),
		.done           (done),
		.hit            (hit),
		.frame_index    (frame_index),
		.evicted_valid  (evicted_valid),
		.evicted_page   (evicted_page),
		.fault_count    (fault_count),
		.final_result   (final_result)
	);

	page_replacement_check u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.start          (start),
		.busy           (busy),
		.page_number    (page_number),
		.last_reference (last_reference),
		.done           (done),
		.hit            (hit),
		.frame_index    (frame_index),
		.evicted_valid  (evicted_valid),
		.evicted_page   (evicted_page),
		.fault_count    (fault_count),
		.final_result   (final_result),
		.fail_count     (fail_count),
		.outstanding    (outstanding)
	);

	// holds start high across back-to-back items; lowers it only for a gap
	task automatic send_ref(logic [PAGE_IN_W-1:0] page, logic last, int unsigned gap);
		page_number <= page;
		last_reference <= last;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 || busy)
			@(posedge clk);
	endtask

	task automatic set_policy(policy_t pol, logic [4:0] frames);
		cfg_index <= REG_POLICY_MODE;
		cfg_data <= CFG_DATA_W'(pol);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_FRAMES_USED;
		cfg_data <= frames;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		#10ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		logic [PAGE_IN_W-1:0] page_pool [POOL_DEPTH];
		logic [PAGE_IN_W-1:0] page;
		logic [4:0]           frames;
		int unsigned          sent;
		int unsigned          phase;
		int unsigned          phase_len;
		int unsigned          n_eff;
		int unsigned          span;
		bit                   burst;
		logic [4:0]           frame_extremes [6];

		frame_extremes = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd8};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: two frames under FIFO, then LRU on the same contents
		set_policy(POLICY_FIFO, 5'd2);
		send_ref(16'h0000, 1'b0, 0);
		send_ref(16'hFFFF, 1'b0, 0);
		send_ref(16'h0000, 1'b0, 2);
		send_ref(16'h1234, 1'b0, 0);
		send_ref(16'hFFFF, 1'b0, 0);
		drain_results();
		set_policy(POLICY_LRU, 5'd2);
		send_ref(16'hFFFF, 1'b0, 0);
		send_ref(16'h5555, 1'b0, 1);
		send_ref(16'hAAAA, 1'b0, 0);
		send_ref(16'h5555, 1'b0, 0);
		drain_results();
		// clock with a third frame, hand runs round clearing reference bits
		set_policy(POLICY_CLOCK, 5'd3);
		send_ref(16'h0001, 1'b0, 0);
		send_ref(16'h5555, 1'b0, 0);
		send_ref(16'hAAAA, 1'b0, 0);
		send_ref(16'h0001, 1'b0, 0);
		send_ref(16'h0002, 1'b0, 3);
		send_ref(16'h0003, 1'b0, 0);
		drain_results();
		// spare policy code, zero frame count acts as one
		set_policy(policy_t'(2'd3), 5'd0);
		send_ref(16'h0003, 1'b0, 0);
		send_ref(16'h8000, 1'b0, 0);
		send_ref(16'h8000, 1'b0, 0);
		drain_results();
		// count above the frame total; the hand may sit beyond a smaller count
		set_policy(POLICY_CLOCK, 5'd31);
		send_ref(16'h7FFF, 1'b0, 0);
		send_ref(16'h0002, 1'b1, 0);
		drain_results();
		set_policy(POLICY_CLOCK, 5'd2);
		send_ref(16'h4444, 1'b0, 0);
		send_ref(16'h0003, 1'b1, 0);
		drain_results();

		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			frames = (phase < 6) ? frame_extremes[phase] :
				((($urandom_range(0, 7)) == 0) ? 5'($urandom_range(17, 31))
				: 5'($urandom_range(1, 16)));
			set_policy(policy_t'(2'(phase % 4)), frames);
			n_eff = (frames == 0) ? 1 : ((frames > 16) ? 16 : frames);
			// working set a little larger than the frame count keeps both hits and faults
			span = n_eff + $urandom_range(0, 5);
			if (span > POOL_DEPTH)
				span = POOL_DEPTH;
			foreach (page_pool[i])
				page_pool[i] = PAGE_IN_W'($urandom);
			burst = ($urandom_range(0, 2) == 0);
			phase_len = $urandom_range(40, 120);
			for (int unsigned k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
				if ($urandom_range(0, 6) == 0)
					page = PAGE_IN_W'($urandom);
				else
					page = page_pool[$urandom_range(0, span - 1)];
				// working set drifts now and then
				if ($urandom_range(0, 19) == 0)
					page_pool[$urandom_range(0, span - 1)] = PAGE_IN_W'($urandom);
				send_ref(page, ($urandom_range(0, 15) == 0),
					burst ? 0 : $urandom_range(0, 9));
				sent++;
				if ($urandom_range(0, 63) == 0)
					drain_results();
			end
			drain_results();
			phase++;
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (outstanding != 0)
			$error("results missing at end: %0d", outstanding);
		if (fail_count == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
